/* hdl/lru_key_cache_unit_defines.svh */
// Assertion macros shared by the cache top level.
`ifndef LRU_KEY_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_CACHE_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define LKC_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define LKC_CHECK_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);

`endif

/* hdl/lkc_pkg.sv */
package lkc_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W       = 64;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 5;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Per-cell update controls.
    typedef struct packed {
        logic clear;  // drop the entry
        logic shift;  // take the neighbour's entry
        logic trim;   // invalidate the shifted entry if it falls past the limit
    } cell_ctrl_t;

endpackage

/* hdl/lkc_cell.sv */
// One recency position of the cache: holds a key, its slot handle and a valid bit.
module lkc_cell #(
    parameter int IDX    = 0,
    parameter int SLOT_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lkc_pkg::cell_ctrl_t      ctrl,
    input  logic [CNT_W-1:0]         lim,
    input  logic [lkc_pkg::KEY_W-1:0] probe_key,
    input  logic [lkc_pkg::KEY_W-1:0] prev_key,
    input  logic [SLOT_W-1:0]        prev_slot,
    input  logic                     prev_valid,
    output logic [lkc_pkg::KEY_W-1:0] key,
    output logic [SLOT_W-1:0]        slot,
    output logic                     valid,
    output logic                     match,
    output logic                     keep
);

    logic [lkc_pkg::KEY_W-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic                      valid_reg, valid_next;
    logic                      in_limit;

    // This position survives a trimming (inserting) shift only if it lies below the limit.
    assign in_limit = CNT_W'(IDX) < lim;

    always_comb
    begin
        key_next   = key_reg;
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            key_next   = prev_key;
            slot_next  = prev_slot;
            valid_next = prev_valid && (!ctrl.trim || in_limit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        slot_reg <= slot_next;
    end

    assign key   = key_reg;
    assign slot  = slot_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (key_reg == probe_key);
    // Entry stays through an insert only if it sits before the last kept position.
    assign keep  = valid_reg && (CNT_W'(IDX + 1) < lim);

endmodule

/* hdl/lru_key_cache_unit.sv */
// Channel   Direction  Handshake                Contents
// s_*       in         s_tvalid / s_tready      one command: key, create flag, command code
// m_*       out        m_tvalid / m_tready      one result per command
// cfg_*     in         cfg_valid / cfg_ready    max_entries register write
//
// For every command the key is compared against all cells at the input transfer,
// and the cell row is updated in the update state once the output register is free
// to take the result, which is loaded into it at the same time.
// The output register decouples the sides; a stalled result holds the block in its update state.
// Reset empties the table at once and sets max_entries to 16.
module lru_key_cache_unit #(
    parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream. tdata: key[63:0], create_ok[64], zero fill[71:65].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lkc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // tuser: cmd[1:0].
    input  logic [lkc_pkg::CMD_W-1:0]       s_tuser,
    // Output stream. tdata: hit[0], inserted[1], slot[5:2], evicted[6],
    // evicted_key[70:7], entry_count[75:71], zero fill[79:76].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lkc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration: max_entries write.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lkc_pkg::CFG_W-1:0]       cfg_data
);

`include "lru_key_cache_unit_defines.svh"

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LIM_W  = (CNT_W > lkc_pkg::CFG_W) ? CNT_W : lkc_pkg::CFG_W;
    localparam int KEY_W  = lkc_pkg::KEY_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [lkc_pkg::CFG_W-1:0] max_entries_reg;
    logic [CNT_W-1:0]          count_reg, count_next;

    // Command held between its lookup and its update.
    lkc_pkg::cmd_t             cmd_reg;
    logic [KEY_W-1:0]          key_reg;
    logic                      create_reg;
    logic [ENTRIES-1:0]        hit_vec_reg;
    logic [SLOT_W-1:0]         hit_slot_reg;
    logic [SLOT_W-1:0]         free_slot_reg;
    logic                      evict_reg;
    logic [KEY_W-1:0]          ev_key_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [lkc_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Cell row.
    lkc_pkg::cell_ctrl_t       ctrl     [ENTRIES];
    logic [KEY_W-1:0]          c_key    [ENTRIES];
    logic [SLOT_W-1:0]         c_slot   [ENTRIES];
    logic [ENTRIES-1:0]        c_valid;
    logic [ENTRIES-1:0]        c_match;
    logic [ENTRIES-1:0]        c_keep;
    logic [KEY_W-1:0]          front_key;
    logic [SLOT_W-1:0]         front_slot;

    logic [LIM_W-1:0]          lim_wide;
    logic [CNT_W-1:0]          lim;
    logic                      s_xfer;
    logic                      upd_go;

    logic [SLOT_W-1:0]         probe_slot;
    logic [SLOT_W-1:0]         probe_free;
    logic [KEY_W-1:0]          probe_last_key;
    logic [ENTRIES-1:0]        used_vec;
    logic [ENTRIES-1:0]        hit_above;

    logic                      hit_any;
    logic                      do_ins;
    logic                      do_mtf;
    logic                      r_hit;
    logic                      r_evicted;
    logic [SLOT_W-1:0]         r_slot;
    logic [KEY_W-1:0]          r_ev_key;

    // Effective limit: zero acts as one, values beyond the table as its size.
    always_comb
    begin
        lim_wide = LIM_W'(max_entries_reg);
        if (lim_wide == '0)
        begin
            lim_wide = LIM_W'(1);
        end
        else if (lim_wide > LIM_W'(ENTRIES))
        begin
            lim_wide = LIM_W'(ENTRIES);
        end
    end
    assign lim = CNT_W'(lim_wide);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= lkc_pkg::MAX_ENTRIES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_entries_reg <= cfg_data;
        end
    end

    // Cells are kept in recency order: position 0 is the most recent entry and
    // the valid entries always occupy positions 0 to count-1.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KEY_W-1:0]  prev_key;
        logic [SLOT_W-1:0] prev_slot;
        logic              prev_valid;

        if (i == 0)
        begin : g_head
            assign prev_key   = front_key;
            assign prev_slot  = front_slot;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_key   = c_key[i-1];
            assign prev_slot  = c_slot[i-1];
            assign prev_valid = c_valid[i-1];
        end

        lkc_cell #(
            .IDX    (i),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl[i]),
            .lim        (lim),
            .probe_key  (s_tdata[KEY_W-1:0]),
            .prev_key   (prev_key),
            .prev_slot  (prev_slot),
            .prev_valid (prev_valid),
            .key        (c_key[i]),
            .slot       (c_slot[i]),
            .valid      (c_valid[i]),
            .match      (c_match[i]),
            .keep       (c_keep[i])
        );
    end

    // Lookup side, evaluated against the incoming key during the input transfer.
    // The hit slot is the slot of the matching cell; the free slot is the lowest
    // slot not held by an entry that survives eviction; the evicted key is the
    // one in the last valid position.
    always_comb
    begin
        probe_slot     = '0;
        probe_last_key = '0;
        used_vec       = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (c_match[i])
            begin
                probe_slot = probe_slot | c_slot[i];
            end
            if (c_keep[i])
            begin
                used_vec[c_slot[i]] = 1'b1;
            end
            if (c_valid[i] && ((i == ENTRIES - 1) || !c_valid[(i + 1) % ENTRIES]))
            begin
                probe_last_key = probe_last_key | c_key[i];
            end
        end
    end

    always_comb
    begin
        probe_free = '0;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if (!used_vec[j])
            begin
                probe_free = SLOT_W'(j);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign upd_go   = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            cmd_reg       <= lkc_pkg::cmd_t'(s_tuser);
            key_reg       <= s_tdata[KEY_W-1:0];
            create_reg    <= s_tdata[KEY_W];
            hit_vec_reg   <= c_match;
            hit_slot_reg  <= probe_slot;
            free_slot_reg <= probe_free;
            evict_reg     <= (count_reg >= lim);
            ev_key_reg    <= probe_last_key;
        end
    end

    // Update side: what the held command does to the cell row.
    assign hit_any = |hit_vec_reg;
    assign do_ins  = (cmd_reg == lkc_pkg::CMD_INSERT) && !hit_any && create_reg;
    assign do_mtf  = hit_any
                     && ((cmd_reg == lkc_pkg::CMD_INSERT) || (cmd_reg == lkc_pkg::CMD_LOOKUP));

    // A hit at position p moves positions 0 to p-1 down by one and p to the front.
    always_comb
    begin
        hit_above = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (i == ENTRIES - 1)
            begin
                hit_above[i] = hit_vec_reg[i];
            end
            else
            begin
                hit_above[i] = hit_vec_reg[i] | hit_above[(i + 1) % ENTRIES];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ctrl[i].clear = upd_go && (cmd_reg == lkc_pkg::CMD_CLEAR);
            ctrl[i].shift = upd_go && (do_ins || (do_mtf && hit_above[i]));
            ctrl[i].trim  = do_ins;
        end
    end

    // On a hit the front entry is the hit key itself, so the key is the same either way.
    assign front_key  = key_reg;
    assign front_slot = do_ins ? free_slot_reg : hit_slot_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd_reg == lkc_pkg::CMD_CLEAR)
        begin
            count_next = '0;
        end
        else if (do_ins)
        begin
            count_next = (evict_reg ? (lim - CNT_W'(1)) : count_reg) + CNT_W'(1);
        end
    end

    assign r_hit     = hit_any && (cmd_reg != lkc_pkg::CMD_CLEAR);
    assign r_evicted = do_ins && evict_reg;
    assign r_ev_key  = r_evicted ? ev_key_reg : '0;

    always_comb
    begin
        r_slot = '0;
        if (r_hit)
        begin
            r_slot = hit_slot_reg;
        end
        else if (do_ins)
        begin
            r_slot = free_slot_reg;
        end
    end

    always_comb
    begin
        m_tdata_next = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (upd_go)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {
                4'b0000,
                lkc_pkg::COUNT_OUT_W'(count_next),
                r_ev_key,
                r_evicted,
                lkc_pkg::SLOT_OUT_W'(r_slot),
                do_ins,
                r_hit
            };
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (upd_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Valid cells form an unbroken run from the front of the row.
    `LKC_CHECK(a_valid_packed, (c_valid & (c_valid + ENTRIES'(1))) == '0, "valid cells not packed")
    // The entry count tracks the number of valid cells.
    `LKC_CHECK(a_count_match, CNT_W'($countones(c_valid)) == count_reg, "entry count mismatch")
    // Every accepted command is followed by its update cycle.
    `LKC_CHECK_NEXT(a_accept_upd, s_xfer, state_reg == ST_UPD, "no update after accept")
    // An eviction only ever comes with an insertion.
    `LKC_CHECK(a_evict_ins, !m_tvalid_reg || !m_tdata_reg[6] || m_tdata_reg[1], "evict without insert")

endmodule

/* tb/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Widths taken over from the package.
    localparam int KEY_W       = lkc_pkg::KEY_W;
    localparam int CMD_W       = lkc_pkg::CMD_W;
    localparam int CFG_W       = lkc_pkg::CFG_W;
    localparam int SLOT_OUT_W  = lkc_pkg::SLOT_OUT_W;
    localparam int COUNT_OUT_W = lkc_pkg::COUNT_OUT_W;
    localparam int IN_TDATA_W  = lkc_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = lkc_pkg::OUT_TDATA_W;

    // Table geometry and run limits.
    localparam int TABLE_SIZE    = lkc_pkg::ENTRIES_DEF;
    localparam int POOL_SIZE     = 24;
    localparam int PHASE_COUNT   = 7;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 40;

    // One result as the block reports it, in the order of the output tdata fields.
    typedef struct packed {
        logic                   hit;
        logic                   inserted;
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   evicted;
        logic [KEY_W-1:0]       evicted_key;
        logic [COUNT_OUT_W-1:0] entry_count;
    } outcome_t;

    // One row of the directed table. Rows marked as known carry their result
    // typed in; the others take the result from the predictor.
    typedef struct {
        lkc_pkg::cmd_t    cmd;
        logic [KEY_W-1:0] key;
        logic             create_ok;
        bit               known;
        outcome_t         want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = lkc_pkg::CMD_INSERT;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;

    // The predictor's own copy of the table and of the limit register.
    logic [KEY_W-1:0] tag_key [TABLE_SIZE];
    bit               tag_live [TABLE_SIZE];
    int unsigned      tag_age [TABLE_SIZE];
    int unsigned      live_entries;
    int unsigned      entry_limit;

    // Results still owed by the block, oldest first.
    outcome_t pending_outcomes[$];

    int          mismatches = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    // A long receiver hold-off is asked for by the stimulus process and carried
    // out by the receiver process; each side counts its own half.
    int          holds_asked = 0;
    int          holds_served = 0;
    int          hold_left = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    directed_row_t    directed_rows[$];

    lru_key_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Works out the result of one command and advances the predicted table.
    // The limit is clamped to the range 1 to the table size. An insert first
    // drops every entry whose rank would fall past the limit, which after the
    // limit has been lowered can be several entries at once; the reported
    // evicted key is then the least recent of them.
    function automatic outcome_t cache_outcome(lkc_pkg::cmd_t cmd, logic [KEY_W-1:0] key,
                                               logic create_ok);
        outcome_t    res;
        int          i;
        int          found;
        int          free_idx;
        int unsigned lim;
        int unsigned worst;
        int unsigned old_rank;
        res = '0;
        found = -1;
        free_idx = -1;
        worst = 0;
        if (cmd == lkc_pkg::CMD_CLEAR)
        begin
            for (i = 0; i < TABLE_SIZE; i++)
            begin
                tag_key[i] = '0;
                tag_live[i] = 1'b0;
                tag_age[i] = 0;
            end
            live_entries = 0;
        end
        else
        begin
            for (i = 0; i < TABLE_SIZE; i++)
                if (found < 0 && tag_live[i] && tag_key[i] == key)
                    found = i;
            if (found >= 0)
            begin
                res.hit = 1'b1;
                res.slot = SLOT_OUT_W'(found);
                // A query reports presence but leaves the recency order alone.
                if (cmd != lkc_pkg::CMD_QUERY)
                begin
                    old_rank = tag_age[found];
                    for (i = 0; i < TABLE_SIZE; i++)
                        if (tag_live[i] && tag_age[i] < old_rank)
                            tag_age[i]++;
                    tag_age[found] = 0;
                end
            end
            else if (cmd == lkc_pkg::CMD_INSERT && create_ok)
            begin
                lim = entry_limit;
                if (lim < 1)
                    lim = 1;
                if (lim > TABLE_SIZE)
                    lim = TABLE_SIZE;
                for (i = 0; i < TABLE_SIZE; i++)
                begin
                    if (tag_live[i] && tag_age[i] + 1 >= lim)
                    begin
                        if (!res.evicted || tag_age[i] > worst)
                        begin
                            worst = tag_age[i];
                            res.evicted_key = tag_key[i];
                        end
                        res.evicted = 1'b1;
                        tag_live[i] = 1'b0;
                        tag_age[i] = 0;
                        if (live_entries > 0)
                            live_entries--;
                    end
                end
                for (i = 0; i < TABLE_SIZE; i++)
                begin
                    if (tag_live[i])
                        tag_age[i]++;
                    else if (free_idx < 0)
                        free_idx = i;
                end
                if (free_idx >= 0)
                begin
                    tag_key[free_idx] = key;
                    tag_live[free_idx] = 1'b1;
                    tag_age[free_idx] = 0;
                    live_entries++;
                    res.inserted = 1'b1;
                    res.slot = SLOT_OUT_W'(free_idx);
                end
            end
        end
        res.entry_count = COUNT_OUT_W'(live_entries);
        return res;
    endfunction

    function automatic directed_row_t step_row(lkc_pkg::cmd_t cmd, logic [KEY_W-1:0] key,
                                               logic create_ok);
        directed_row_t r;
        r.cmd = cmd;
        r.key = key;
        r.create_ok = create_ok;
        r.known = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Known rows in this table never evict, so only the remaining fields are given.
    function automatic directed_row_t known_row(lkc_pkg::cmd_t cmd, logic [KEY_W-1:0] key,
                                                logic create_ok, logic hit,
                                                logic inserted, int slot, int count);
        directed_row_t r;
        r = step_row(cmd, key, create_ok);
        r.known = 1'b1;
        r.want.hit = hit;
        r.want.inserted = inserted;
        r.want.slot = SLOT_OUT_W'(slot);
        r.want.entry_count = COUNT_OUT_W'(count);
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [KEY_W-1:0] seen,
                                 logic [KEY_W-1:0] wanted);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %h, expected %h",
                     cycle_count, what, seen, wanted);
        mismatches++;
    endtask

    // Offers one command and waits for its transfer. The expectation is queued
    // at the edge of the transfer, so the predictor sees commands in the order
    // the block accepted them. Afterwards the sender may idle at random, at the phase's idle percentage.
    task automatic offer_command(lkc_pkg::cmd_t cmd, logic [KEY_W-1:0] key,
                                 logic create_ok, bit known, outcome_t want);
        outcome_t predicted;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(IN_TDATA_W - KEY_W - 1){1'b0}}, create_ok, key};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = cache_outcome(cmd, key, create_ok);
        pending_outcomes.push_back(known ? want : predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every owed result has arrived, then lets the block settle.
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The limit register is only written while the block is empty of work.
    task automatic write_entry_limit(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        entry_limit = value;
    endtask

    // Receiver: random stalls at the rate of the current phase, or a long
    // hold-off when the stimulus asks for one, so that the block fills up and
    // pushes back on its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: each output transfer is held against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t seen;
        outcome_t wanted;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.hit = m_tdata[0];
            seen.inserted = m_tdata[1];
            seen.slot = m_tdata[5:2];
            seen.evicted = m_tdata[6];
            seen.evicted_key = m_tdata[70:7];
            seen.entry_count = m_tdata[75:71];
            if (pending_outcomes.size() == 0)
                flag_mismatch("unexpected result tdata", m_tdata[63:0], '0);
            else
            begin
                wanted = pending_outcomes.pop_front();
                if (seen.hit !== wanted.hit)
                    flag_mismatch("hit", KEY_W'(seen.hit), KEY_W'(wanted.hit));
                if (seen.inserted !== wanted.inserted)
                    flag_mismatch("inserted", KEY_W'(seen.inserted),
                                  KEY_W'(wanted.inserted));
                if (seen.slot !== wanted.slot)
                    flag_mismatch("slot", KEY_W'(seen.slot), KEY_W'(wanted.slot));
                if (seen.evicted !== wanted.evicted)
                    flag_mismatch("evicted", KEY_W'(seen.evicted), KEY_W'(wanted.evicted));
                if (seen.evicted_key !== wanted.evicted_key)
                    flag_mismatch("evicted_key", seen.evicted_key, wanted.evicted_key);
                if (seen.entry_count !== wanted.entry_count)
                    flag_mismatch("entry_count", KEY_W'(seen.entry_count),
                                  KEY_W'(wanted.entry_count));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int               ph;
        int               n;
        int               i;
        int               pick;
        lkc_pkg::cmd_t    cmd;
        logic [KEY_W-1:0] key;
        logic             create_ok;
        int               phase_limit [PHASE_COUNT];
        int               phase_idle  [PHASE_COUNT];
        int               phase_stall [PHASE_COUNT];

        // Per phase: limit written, sender idle and receiver stall percentages.
        // The limit runs through the reset value, zero (acts as one), the
        // register maximum (clamped to the table size), one, just above the
        // table size, a random middle value and a small value. Going from 31
        // to 1 with a full table makes the next insert drop many entries at once.
        phase_limit = '{16, 0, 31, 1, 17, 9, 3};
        phase_idle  = '{0, 76, 0, 8, 0, 76, 8};
        phase_stall = '{0, 0, 76, 8, 0, 0, 8};

        for (i = 0; i < TABLE_SIZE; i++)
        begin
            tag_key[i] = '0;
            tag_live[i] = 1'b0;
            tag_age[i] = 0;
        end
        live_entries = 0;
        entry_limit = lkc_pkg::MAX_ENTRIES_RST;

        // Directed part, starting from the reset state with a limit of 16.
        directed_rows = '{
            known_row(lkc_pkg::CMD_QUERY,  64'h0, 1'b0, 1'b0, 1'b0, 0, 0),
            known_row(lkc_pkg::CMD_LOOKUP, '1,    1'b1, 1'b0, 1'b0, 0, 0),
            // A refused insert stores nothing.
            known_row(lkc_pkg::CMD_INSERT, 64'h0, 1'b0, 1'b0, 1'b0, 0, 0),
            known_row(lkc_pkg::CMD_INSERT, 64'h0, 1'b1, 1'b0, 1'b1, 0, 1),
            known_row(lkc_pkg::CMD_INSERT, '1,    1'b1, 1'b0, 1'b1, 1, 2),
            known_row(lkc_pkg::CMD_QUERY,  64'h0, 1'b1, 1'b1, 1'b0, 0, 2),
            known_row(lkc_pkg::CMD_LOOKUP, '1,    1'b0, 1'b1, 1'b0, 1, 2),
            // A hit needs no successful creation.
            known_row(lkc_pkg::CMD_INSERT, 64'h0, 1'b0, 1'b1, 1'b0, 0, 2),
            // Clear ignores its key and flag and reports all zero.
            known_row(lkc_pkg::CMD_CLEAR,  '1,    1'b1, 1'b0, 1'b0, 0, 0),
            known_row(lkc_pkg::CMD_INSERT, '1,    1'b1, 1'b0, 1'b1, 0, 1),
            step_row(lkc_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 1'b1),
            step_row(lkc_pkg::CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1),
            step_row(lkc_pkg::CMD_LOOKUP, 64'h5555_5555_5555_5555, 1'b0),
            step_row(lkc_pkg::CMD_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0),
            step_row(lkc_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 1'b1),
            // Differs from a stored key in the top bit only.
            step_row(lkc_pkg::CMD_QUERY,  64'h0000_0000_0000_0000, 1'b1),
            step_row(lkc_pkg::CMD_INSERT, 64'h0000_0000_0000_0001, 1'b1),
            step_row(lkc_pkg::CMD_LOOKUP, '1, 1'b1),
            known_row(lkc_pkg::CMD_CLEAR,  64'h0, 1'b0, 1'b0, 1'b0, 0, 0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            offer_command(directed_rows[r].cmd, directed_rows[r].key,
                          directed_rows[r].create_ok, directed_rows[r].known,
                          directed_rows[r].want);

        // Random part. Commands mostly reuse a small pool of keys so that hits,
        // re-inserts and evictions are frequent; some pool keys differ from
        // another in a single bit, and a few commands use fresh random keys.
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain_outcomes();
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            if (ph == 5)
                write_entry_limit(CFG_W'($urandom_range(2, 15)));
            else
                write_entry_limit(CFG_W'(phase_limit[ph]));
            for (i = 0; i < POOL_SIZE; i++)
            begin
                if (i > 0 && $urandom_range(3) == 0)
                    key_pool[i] = key_pool[0] ^ (64'h1 << $urandom_range(63));
                else
                    key_pool[i] = {$urandom, $urandom};
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Phase 4 runs without idling; a long receiver hold-off early
                // on backs the block up, and later the sender waits for the
                // block to empty before carrying on.
                if (ph == 4 && n == 20)
                    holds_asked++;
                if (ph == 4 && n == 150)
                    drain_outcomes();
                pick = $urandom_range(99);
                if (pick < 48)
                    cmd = lkc_pkg::CMD_INSERT;
                else if (pick < 70)
                    cmd = lkc_pkg::CMD_LOOKUP;
                else if (pick < 97)
                    cmd = lkc_pkg::CMD_QUERY;
                else
                    cmd = lkc_pkg::CMD_CLEAR;
                if ($urandom_range(7) == 0)
                    key = {$urandom, $urandom};
                else
                    key = key_pool[$urandom_range(POOL_SIZE - 1)];
                create_ok = ($urandom_range(9) != 0);
                offer_command(cmd, key, create_ok, 1'b0, '0);
            end
        end

        drain_outcomes();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* lru_key_cache_unit.f */
+incdir+hdl
hdl/lkc_pkg.sv
hdl/lkc_cell.sv
hdl/lru_key_cache_unit.sv
tb/testbench.sv
